FILE: rtl/fnpc_pkg.sv
// Package: shared types and constants for the four-neighbor peak clamp core.
`timescale 1ns / 1ps
`default_nettype none
package fnpc_pkg;

    localparam int DATA_W = 32;
    localparam int ROWS_W = 12;
    localparam int COLS_W = 6;

    // register index as decoded from paddr[2]
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_CTR,
        ST_RD_RGT,
        ST_CAPT,
        ST_EMIT
    } fnpc_state_t;

    typedef struct packed {
        logic load_pix;
        logic cap_ctr;
        logic cap_rgt;
        logic commit;
        logic has_result;
        logic up_ok;
        logic left_ok;
        logic right_ok;
        logic down_ok;
        logic wr_pending;
        logic run_last;
        logic frame_done;
    } fnpc_cmd_t;

    typedef struct packed {
        logic out_free;
    } fnpc_sts_t;

endpackage
`default_nettype wire

FILE: rtl/four_neighbor_peak_clamp_core.sv
// Top level: four-neighbor local peak clamp with APB registers and stream ports.
// A beat releases the result of the pixel above it through the read, capture and emit states
// (one read per line-store port per cycle, three reads and a commit per pixel); emit waits
// for output space, beats are taken only in idle, and a frame's last beat flushes the final row.
// Reset: position counters clear, frame_rows and frame_cols read 1, output empty;
// line stores are not cleared and are written before they are read.
`timescale 1ns / 1ps
`default_nettype none
module four_neighbor_peak_clamp_core #(
    parameter int MAX_COLS   = 63,
    parameter int PIXEL_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] pixel_in
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] pixel_out
    output logic             m_tlast,   // run_last
    output logic             m_tuser    // [0] frame_done
);
    import fnpc_pkg::*;

    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [ROWS_W-1:0] frame_rows_reg;
    logic [COLS_W-1:0] frame_cols_reg;
    logic              cfg_wr;
    fnpc_cmd_t         cmd;
    fnpc_sts_t         sts;
    logic [AW-1:0]     fin_raddr;
    logic [AW-1:0]     pend_raddr;
    logic [AW-1:0]     waddr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= ROWS_W'(1);
            frame_cols_reg <= COLS_W'(1);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_ROWS: frame_rows_reg <= pwdata[ROWS_W-1:0];
                REG_COLS: frame_cols_reg <= pwdata[COLS_W-1:0];
                default:  frame_rows_reg <= frame_rows_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ROWS: prdata = 32'(frame_rows_reg);
            REG_COLS: prdata = 32'(frame_cols_reg);
            default:  prdata = '0;
        endcase
    end

    fnpc_ctrl #(.MAX_COLS(MAX_COLS), .AW(AW)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_rows (frame_rows_reg),
        .frame_cols (frame_cols_reg),
        .cfg_wr     (cfg_wr),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .sts        (sts),
        .cmd        (cmd),
        .fin_raddr  (fin_raddr),
        .pend_raddr (pend_raddr),
        .waddr      (waddr)
    );

    fnpc_datapath #(.MAX_COLS(MAX_COLS), .PIXEL_BITS(PIXEL_BITS), .AW(AW)) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .pixel_in   (s_tdata),
        .fin_raddr  (fin_raddr),
        .pend_raddr (pend_raddr),
        .waddr      (waddr),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
`default_nettype wire

FILE: rtl/fnpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fnpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 63,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/fnpc_ctrl.sv
// Controller: frame position counters, row flush sequencing and datapath commands.
`timescale 1ns / 1ps
`default_nettype none
module fnpc_ctrl #(
    parameter int MAX_COLS = 63,
    parameter int AW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [fnpc_pkg::ROWS_W-1:0] frame_rows,
    input  wire logic [fnpc_pkg::COLS_W-1:0] frame_cols,
    input  wire logic                      cfg_wr,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire fnpc_pkg::fnpc_sts_t       sts,
    output fnpc_pkg::fnpc_cmd_t            cmd,
    output logic [AW-1:0]                  fin_raddr,
    output logic [AW-1:0]                  pend_raddr,
    output logic [AW-1:0]                  waddr
);
    import fnpc_pkg::*;

    localparam int CW = $clog2(MAX_COLS + 1);

    fnpc_state_t       state_reg, state_next;
    logic [AW-1:0]     col_reg, col_next;
    logic [ROWS_W-1:0] row_reg, row_next;
    logic [AW-1:0]     fc_reg, fc_next;
    logic              flush_reg, flush_next;

    logic [ROWS_W-1:0] rows_eff;
    logic [CW-1:0]     cols_eff;
    logic [AW-1:0]     idx;
    logic [CW-1:0]     idx_inc;
    logic              idx_end;
    logic              row_end;
    logic              frame_last;
    logic              has_result;
    logic              proceed;
    logic [AW-1:0]     right_idx;

    always_comb
    begin
        rows_eff = (frame_rows == '0) ? ROWS_W'(1) : frame_rows;
        if (frame_cols == '0)
        begin
            cols_eff = CW'(1);
        end
        else if (int'(frame_cols) > MAX_COLS)
        begin
            cols_eff = CW'(MAX_COLS);
        end
        else
        begin
            cols_eff = CW'(frame_cols);
        end
    end

    assign idx        = flush_reg ? fc_reg : col_reg;
    assign idx_inc    = CW'(idx) + CW'(1);
    assign idx_end    = (idx_inc == cols_eff);
    assign right_idx  = idx_end ? idx : AW'(idx_inc);
    assign row_end    = ((row_reg + ROWS_W'(1)) == rows_eff);
    assign frame_last = idx_end && row_end;
    assign has_result = flush_reg || (row_reg != '0);
    assign proceed    = !has_result || sts.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            fc_reg    <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            fc_reg    <= fc_next;
            flush_reg <= flush_next;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        fc_next    = fc_reg;
        flush_next = flush_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_wr)
                begin
                    col_next = '0;
                    row_next = '0;
                end
                else if (s_tvalid)
                begin
                    state_next = ST_RD_CTR;
                end
            end
            ST_RD_CTR: state_next = ST_RD_RGT;
            ST_RD_RGT: state_next = ST_CAPT;
            ST_CAPT:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (proceed)
                begin
                    if (flush_reg)
                    begin
                        if (idx_end)
                        begin
                            flush_next = 1'b0;
                            fc_next    = '0;
                            col_next   = '0;
                            row_next   = '0;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            fc_next    = fc_reg + AW'(1);
                            state_next = ST_RD_CTR;
                        end
                    end
                    else if (frame_last)
                    begin
                        flush_next = 1'b1;
                        fc_next    = '0;
                        state_next = ST_RD_CTR;
                    end
                    else
                    begin
                        if (idx_end)
                        begin
                            col_next = '0;
                            row_next = row_reg + ROWS_W'(1);
                        end
                        else
                        begin
                            col_next = col_reg + AW'(1);
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready       = (state_reg == ST_IDLE) && !cfg_wr;
        cmd            = '0;
        cmd.load_pix   = (state_reg == ST_IDLE) && !cfg_wr && s_tvalid;
        cmd.cap_ctr    = (state_reg == ST_RD_RGT);
        cmd.cap_rgt    = (state_reg == ST_CAPT);
        cmd.commit     = (state_reg == ST_EMIT) && proceed;
        cmd.has_result = has_result;
        cmd.up_ok      = flush_reg ? (rows_eff >= ROWS_W'(2)) : (row_reg >= ROWS_W'(2));
        cmd.left_ok    = (idx != '0);
        cmd.right_ok   = !idx_end;
        cmd.down_ok    = !flush_reg;
        cmd.wr_pending = !flush_reg;
        cmd.run_last   = flush_reg ? idx_end : !frame_last;
        cmd.frame_done = flush_reg && idx_end;
        fin_raddr      = idx;
        pend_raddr     = (state_reg == ST_RD_RGT) ? right_idx : idx;
        waddr          = idx;
    end

endmodule
`default_nettype wire

FILE: rtl/fnpc_datapath.sv
// Datapath: line stores, neighbor capture, clamp logic and output register.
`timescale 1ns / 1ps
`default_nettype none
module fnpc_datapath #(
    parameter int MAX_COLS   = 63,
    parameter int PIXEL_BITS = 32,
    parameter int AW         = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire fnpc_pkg::fnpc_cmd_t        cmd,
    output fnpc_pkg::fnpc_sts_t             sts,
    input  wire logic [fnpc_pkg::DATA_W-1:0] pixel_in,
    input  wire logic [AW-1:0]              fin_raddr,
    input  wire logic [AW-1:0]              pend_raddr,
    input  wire logic [AW-1:0]              waddr,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [fnpc_pkg::DATA_W-1:0]     m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);
    import fnpc_pkg::*;

    logic [PIXEL_BITS-1:0] pix_reg;
    logic [PIXEL_BITS-1:0] centre_reg;
    logic [PIXEL_BITS-1:0] up_reg;
    logic [PIXEL_BITS-1:0] right_reg;
    logic [PIXEL_BITS-1:0] left_reg;
    logic [PIXEL_BITS-1:0] out_pix_reg;
    logic                  out_last_reg;
    logic                  out_done_reg;
    logic                  out_valid_reg, out_valid_next;

    logic [PIXEL_BITS-1:0] fin_rdata;
    logic [PIXEL_BITS-1:0] pend_rdata;
    logic [PIXEL_BITS-1:0] best;
    logic                  peak;
    logic [PIXEL_BITS-1:0] clamp_val;
    logic                  emit;

    fnpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS), .AW(AW)) u_final_row (
        .clk   (clk),
        .we    (cmd.commit && cmd.has_result),
        .waddr (waddr),
        .wdata (clamp_val),
        .raddr (fin_raddr),
        .rdata (fin_rdata)
    );

    fnpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS), .AW(AW)) u_pending_row (
        .clk   (clk),
        .we    (cmd.commit && cmd.wr_pending),
        .waddr (waddr),
        .wdata (pix_reg),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

    always_comb
    begin
        best = '0;
        peak = 1'b1;
        if (cmd.down_ok)
        begin
            if (pix_reg > best) best = pix_reg;
            if (centre_reg < pix_reg) peak = 1'b0;
        end
        if (cmd.right_ok)
        begin
            if (right_reg > best) best = right_reg;
            if (centre_reg < right_reg) peak = 1'b0;
        end
        if (cmd.up_ok)
        begin
            if (up_reg > best) best = up_reg;
            if (centre_reg < up_reg) peak = 1'b0;
        end
        if (cmd.left_ok)
        begin
            if (left_reg > best) best = left_reg;
            if (centre_reg < left_reg) peak = 1'b0;
        end
        clamp_val = peak ? best : centre_reg;
    end

    assign emit           = cmd.commit && cmd.has_result;
    assign out_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    assign sts.out_free   = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pix)
        begin
            pix_reg <= pixel_in[PIXEL_BITS-1:0];
        end
        if (cmd.cap_ctr)
        begin
            centre_reg <= pend_rdata;
            up_reg     <= fin_rdata;
        end
        if (cmd.cap_rgt)
        begin
            right_reg <= pend_rdata;
        end
        if (emit)
        begin
            left_reg     <= clamp_val;
            out_pix_reg  <= clamp_val;
            out_last_reg <= cmd.run_last;
            out_done_reg <= cmd.frame_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'(out_pix_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule
`default_nettype wire

FILE: sim/four_neighbor_peak_clamp_core_test.sv
// Testbench for the four-neighbor peak clamp core: directed and random frames against a predictor.
`timescale 1ns / 1ps
module four_neighbor_peak_clamp_core_test;
    import fnpc_pkg::*;

    localparam int MAX_COLS      = 63;
    localparam int RANDOM_PIXELS = 190;
    localparam int IDLE_LIMIT    = 4000;   // cycles with no beat, no register access
    localparam int WORK_GUARD    = 24;     // a beat that makes no result may still be in flight
    localparam int FLUSH_GUARD   = 300;    // a full 63-column flush plus margin

    typedef struct packed {
        logic [DATA_W-1:0] pix;
        logic              last;
        logic              done;
    } clamp_beat_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;    // [31:0] pixel_in
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;    // [31:0] pixel_out
    logic              m_tlast;    // run_last
    logic              m_tuser;    // [0] frame_done

    // predictor state
    logic [DATA_W-1:0] updated_row [MAX_COLS];
    logic [DATA_W-1:0] original_row[MAX_COLS];
    logic [ROWS_W-1:0] rows_reg;
    logic [COLS_W-1:0] cols_reg;
    int unsigned       at_col;
    int unsigned       at_row;
    clamp_beat_t       clamped_q[$];

    int                err_count   = 0;
    int                out_beats   = 0;
    int                burst_left  = 0;
    int                idle_cycles = 0;
    int                stall_left  = 0;
    int                stall_mode  = 0;

    four_neighbor_peak_clamp_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("MISMATCH %s: got %h expected %h (output beat %0d)",
                 what, got, want, out_beats);
    endtask

    // peak: not below any present neighbor -> largest neighbor, else unchanged
    function automatic logic [DATA_W-1:0] peak_clamp(
        input logic [DATA_W-1:0] centre,
        input logic up_ok,    input logic [DATA_W-1:0] up,
        input logic left_ok,  input logic [DATA_W-1:0] left,
        input logic right_ok, input logic [DATA_W-1:0] right,
        input logic down_ok,  input logic [DATA_W-1:0] down);
        logic [DATA_W-1:0] best;
        logic              peak;
        logic [3:0]        ok;
        logic [DATA_W-1:0] nb[4];
        best = '0;
        peak = 1'b1;
        ok = {down_ok, right_ok, up_ok, left_ok};
        nb[0] = left;
        nb[1] = up;
        nb[2] = right;
        nb[3] = down;
        for (int k = 0; k < 4; k++)
        begin
            if (ok[k])
            begin
                if (nb[k] > best) best = nb[k];
                if (centre < nb[k]) peak = 1'b0;
            end
        end
        return peak ? best : centre;
    endfunction

    task automatic take_pixel(input logic [DATA_W-1:0] p);
        int unsigned       rows;
        int unsigned       cols;
        int unsigned       col;
        int unsigned       row;
        logic              frame_end;
        logic [DATA_W-1:0] left_v;
        logic [DATA_W-1:0] right_v;
        clamp_beat_t       r;
        rows = (rows_reg == 0) ? 1 : rows_reg;
        cols = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
        col = at_col;
        row = at_row;
        frame_end = (col + 1 == cols) && (row + 1 == rows);
        if (row >= 1)
        begin
            left_v  = (col >= 1) ? updated_row[col - 1] : '0;
            right_v = (col + 1 < cols) ? original_row[col + 1] : '0;
            r.pix = peak_clamp(original_row[col], row >= 2, updated_row[col],
                               col >= 1, left_v, col + 1 < cols, right_v, 1'b1, p);
            r.last = !frame_end;
            r.done = 1'b0;
            updated_row[col] = r.pix;
            clamped_q = {clamped_q, r};
        end
        original_row[col] = p;
        if (frame_end)
        begin
            // last pixel flushes the final row, no lower neighbor
            for (int unsigned c = 0; c < cols; c++)
            begin
                left_v  = (c >= 1) ? updated_row[c - 1] : '0;
                right_v = (c + 1 < cols) ? original_row[c + 1] : '0;
                r.pix = peak_clamp(original_row[c], rows >= 2, updated_row[c],
                                   c >= 1, left_v, c + 1 < cols, right_v, 1'b0, '0);
                r.last = (c + 1 == cols);
                r.done = (c + 1 == cols);
                updated_row[c] = r.pix;
                clamped_q = {clamped_q, r};
            end
            at_col = 0;
            at_row = 0;
        end
        else if (col + 1 == cols)
        begin
            at_col = 0;
            at_row = row + 1;
        end
        else
        begin
            at_col = col + 1;
        end
    endtask

    task automatic push_pixel(input logic [DATA_W-1:0] pix);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge clk); while (s_tready !== 1'b1);
        take_pixel(pix);
        burst_left--;
    endtask

    task automatic settle_outputs(input int extra);
        s_tvalid <= 1'b0;
        while (clamped_q.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic program_reg(input logic idx, input logic [31:0] value);
        settle_outputs(WORK_GUARD);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (idx == REG_ROWS) rows_reg = value[ROWS_W-1:0];
        else                 cols_reg = value[COLS_W-1:0];
        at_col = 0;
        at_row = 0;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_reg(input logic idx);
        logic [31:0] want;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        want = (idx == REG_ROWS) ? 32'(rows_reg) : 32'(cols_reg);
        if (prdata !== want) report_mismatch("register read", prdata, want);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] draw_pixel(input int style);
        case (style)
            0: return $urandom;
            1: return $urandom_range(0, 3);
            2: case ($urandom_range(0, 3))
                   0: return '0;
                   1: return 32'hFFFF_FFFF;
                   2: return 32'hFFFF_FFFE;
                   default: return 32'h1;
               endcase
            default: return ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 2);
        endcase
    endfunction

    task automatic push_list(input logic [DATA_W-1:0] pix[$]);
        foreach (pix[k]) push_pixel(pix[k]);
    endtask

    // --- tests ---

    task automatic test_reset_defaults();
        read_reg(REG_ROWS);
        read_reg(REG_COLS);
        // 1x1 frames: no neighbors, result is zero
        push_list('{32'h0, 32'hFFFF_FFFF, 32'h1234_5678});
    endtask

    task automatic test_zero_sizes();
        program_reg(REG_ROWS, 32'h0);
        read_reg(REG_ROWS);
        program_reg(REG_COLS, 32'h0);
        read_reg(REG_COLS);
        push_list('{32'hFFFF_FFFF, 32'h8000_0001});
        // upper bits of the write data are dropped
        program_reg(REG_ROWS, 32'hFFFF_F002);
        read_reg(REG_ROWS);
        program_reg(REG_COLS, 32'hFFFF_FFC3);
        read_reg(REG_COLS);
        push_list('{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0});
    endtask

    task automatic test_single_row_and_column();
        program_reg(REG_ROWS, 32'd1);
        program_reg(REG_COLS, 32'd5);
        push_list('{32'd7, 32'd7, 32'd3, 32'd9, 32'd9});
        program_reg(REG_ROWS, 32'd5);
        program_reg(REG_COLS, 32'd1);
        push_list('{32'd4, 32'd4, 32'hFFFF_FFFF, 32'd0, 32'd5});
    endtask

    task automatic test_ties();
        program_reg(REG_ROWS, 32'd3);
        program_reg(REG_COLS, 32'd3);
        push_list('{32'd1, 32'd0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd1, 32'd1, 32'd1});
        push_list('{32'd6, 32'd6, 32'd6, 32'd6, 32'd6, 32'd6, 32'd6, 32'd6, 32'd6});
    endtask

    task automatic test_frame_restart();
        program_reg(REG_ROWS, 32'd3);
        program_reg(REG_COLS, 32'd4);
        for (int k = 0; k < 6; k++) push_pixel(draw_pixel(0));
        // frame left unfinished; the write starts a fresh one
        program_reg(REG_COLS, 32'd4);
        for (int k = 0; k < 12; k++) push_pixel(draw_pixel(3));
    endtask

    task automatic test_size_extremes();
        program_reg(REG_ROWS, 32'd2);
        program_reg(REG_COLS, 32'd63);
        for (int k = 0; k < 2 * 63; k++) push_pixel(draw_pixel(k % 4));
        // tallest frame, left unfinished after a few rows
        program_reg(REG_ROWS, 32'd4095);
        program_reg(REG_COLS, 32'd1);
        for (int k = 0; k < 30; k++) push_pixel(draw_pixel($urandom_range(0, 3)));
    endtask

    task automatic test_random_frames();
        int unsigned sent;
        int unsigned rows;
        int unsigned cols;
        int unsigned n;
        int unsigned stop_at;
        int unsigned pause_at;
        int          style;
        logic        broken;
        logic        reuse;
        sent   = 0;
        broken = 1'b1;
        rows   = 1;
        cols   = 1;
        while (sent < RANDOM_PIXELS)
        begin
            reuse = !broken && ($urandom_range(0, 9) < 4);
            if (!reuse)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    rows = $urandom_range(1, 4);
                    cols = $urandom_range(11, 63);
                end
                else
                begin
                    rows = $urandom_range(1, 6);
                    cols = $urandom_range(1, 10);
                end
                program_reg(REG_ROWS, ($urandom & ~32'hFFF) | rows);
                program_reg(REG_COLS, ($urandom & ~32'h3F) | cols);
            end
            n = rows * cols;
            stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n) : n;
            broken = (stop_at < n);
            pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, stop_at - 1) : n + 1;
            style = $urandom_range(0, 3);
            for (int unsigned i = 0; i < stop_at; i++)
            begin
                if (i == pause_at) settle_outputs(0);
                push_pixel(draw_pixel(style));
            end
            sent += stop_at;
        end
    endtask

    // --- result checking ---

    always @(posedge clk)
    begin
        clamp_beat_t want;
        if (m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            out_beats <= out_beats + 1;
            if (clamped_q.size() == 0)
            begin
                report_mismatch("beat with nothing pending", m_tdata, '0);
            end
            else
            begin
                want = clamped_q.pop_front();
                if (m_tdata !== want.pix) report_mismatch("pixel_out", m_tdata, want.pix);
                if (m_tlast !== want.last)
                    report_mismatch("run_last", 32'(m_tlast), 32'(want.last));
                if (m_tuser !== want.done)
                    report_mismatch("frame_done", 32'(m_tuser), 32'(want.done));
            end
        end
    end

    // receiver back-pressure, with a new random pattern drawn each time stall_left runs out
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 60);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_left % 8 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1)
            || (psel === 1'b1 && penable === 1'b1))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("four_neighbor_peak_clamp_core test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        rows_reg = 1;
        cols_reg = 1;
        at_col   = 0;
        at_row   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_sizes();
        test_single_row_and_column();
        test_ties();
        test_frame_restart();
        test_size_extremes();
        test_random_frames();

        settle_outputs(FLUSH_GUARD);
        if (err_count == 0)
            $display("four_neighbor_peak_clamp_core test passed");
        else
            $display("four_neighbor_peak_clamp_core test failed");
        $finish;
    end

endmodule
